>>> rtl/core/ssm_pkg.sv
package ssm_pkg;

  // Sequence storage limits and field widths.
  localparam int MAX_ITEMS = 1024;
  localparam int VALUE_W   = 20;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int TOTAL_W   = 40;
  localparam int STK_W     = IDX_W + VALUE_W;
  localparam int P1_W      = VALUE_W + CNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_CMP,
    S_POPW,
    S_DRAIN,
    S_DRAINW,
    S_SUM,
    S_FLUSH,
    S_OUT
  } state_e;

  typedef enum logic {
    PASS_RIGHT,
    PASS_LEFT
  } pass_e;

endpackage

>>> rtl/core/ssm_ram.sv
module ssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds its value until the next read enable.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sum_of_subarray_minimums.sv
// Channel  | Direction | Handshake                    | Payload
// request  | in        | start, busy (taken: start&!busy) | value_i, last_i
// result   | out       | done_o strobe, one cycle     | total_o, overflow_o
//
// Loading takes one request per cycle; busy stays low until a request with last_i.
// Finishing a sequence of stored values runs two stack passes, paced by the single
// read port of the value and stack memories, then a summing sweep.
// Reset is asynchronous and active low; memories are not cleared, only written
// entries are ever read. The receiver cannot stall: done_o is high for one cycle.
module sum_of_subarray_minimums
  import ssm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               last_i,
  output logic               done_o,
  output logic [TOTAL_W-1:0] total_o,
  output logic               overflow_o
);

  // Control state.
  state_e             state_q, state_d;
  pass_e              pass_q, pass_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   depth_q, depth_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               ovf_q, ovf_d;
  logic               rd_vld_q, rd_vld_d;
  logic               p1_vld_q, p1_vld_d;
  logic               p2_vld_q, p2_vld_d;
  logic [TOTAL_W-1:0] acc_q, acc_d;

  // Cached top of the index stack; entries below it live in the stack memory.
  logic [IDX_W-1:0]   top_idx_q, top_idx_d;
  logic [VALUE_W-1:0] top_val_q, top_val_d;

  // Summing pipeline payload.
  logic [P1_W-1:0]    p1_q, p1_d;
  logic [CNT_W-1:0]   r1_q, r1_d;
  logic [TOTAL_W-1:0] p2_q, p2_d;

  // Memory ports.
  logic               val_we, val_re;
  logic [IDX_W-1:0]   val_waddr, val_raddr;
  logic [VALUE_W-1:0] val_rdata;
  logic               stk_we, stk_re;
  logic [IDX_W-1:0]   stk_waddr, stk_raddr;
  logic [STK_W-1:0]   stk_rdata;
  logic               rs_we, ls_we, span_re;
  logic [IDX_W-1:0]   span_waddr;
  logic [IDX_W-1:0]   span_wdata;
  logic [IDX_W-1:0]   rs_rdata, ls_rdata;

  logic [IDX_W-1:0]   last_idx;
  logic               pop_hit;
  logic               at_end;
  logic [IDX_W-1:0]   pop_span;
  logic [IDX_W-1:0]   drain_span;
  logic [IDX_W-1:0]   idx_next;

  ssm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_values (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(value_i),
    .re_i   (val_re),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  ssm_ram #(.WIDTH(STK_W), .DEPTH(MAX_ITEMS)) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i({top_idx_q, top_val_q}),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  ssm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_right_span (
    .clk_i  (clk_i),
    .we_i   (rs_we),
    .waddr_i(span_waddr),
    .wdata_i(span_wdata),
    .re_i   (span_re),
    .raddr_i(idx_q),
    .rdata_o(rs_rdata)
  );

  ssm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_left_span (
    .clk_i  (clk_i),
    .we_i   (ls_we),
    .waddr_i(span_waddr),
    .wdata_i(span_wdata),
    .re_i   (span_re),
    .raddr_i(idx_q),
    .rdata_o(ls_rdata)
  );

  // The sequence length is at least one whenever a pass runs.
  assign last_idx = IDX_W'(count_q - CNT_W'(1));

  // The right pass pops on a strictly greater top, the left pass on greater or
  // equal, so a run of equal values is credited to its leftmost member only.
  // The current value sits on the value memory's read data, which holds while
  // the stack is being popped.
  always_comb begin
    if (pass_q == PASS_RIGHT) begin
      pop_hit    = (depth_q != '0) && (top_val_q > val_rdata);
      at_end     = (idx_q == last_idx);
      pop_span   = idx_q - top_idx_q - IDX_W'(1);
      drain_span = last_idx - top_idx_q;
      idx_next   = idx_q + IDX_W'(1);
    end else begin
      pop_hit    = (depth_q != '0) && (top_val_q >= val_rdata);
      at_end     = (idx_q == '0);
      pop_span   = top_idx_q - idx_q - IDX_W'(1);
      drain_span = top_idx_q;
      idx_next   = idx_q - IDX_W'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start && last_i) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: state_d = S_CMP;
      S_CMP: begin
        if (pop_hit) begin
          state_d = (depth_q >= CNT_W'(2)) ? S_POPW : S_CMP;
        end else if (at_end) begin
          state_d = S_DRAIN;
        end
      end
      S_POPW: state_d = S_CMP;
      S_DRAIN: begin
        if (depth_q != '0) begin
          state_d = (depth_q >= CNT_W'(2)) ? S_DRAINW : S_DRAIN;
        end else if (pass_q == PASS_RIGHT) begin
          state_d = S_FETCH;
        end else begin
          state_d = S_SUM;
        end
      end
      S_DRAINW: state_d = S_DRAIN;
      S_SUM: begin
        if (idx_q == last_idx) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!rd_vld_q && !p1_vld_q && !p2_vld_q) begin
          state_d = S_OUT;
        end
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory controls and register updates.
  always_comb begin
    pass_d     = pass_q;
    count_d    = count_q;
    depth_d    = depth_q;
    idx_d      = idx_q;
    ovf_d      = ovf_q;
    acc_d      = acc_q;
    top_idx_d  = top_idx_q;
    top_val_d  = top_val_q;
    rd_vld_d   = 1'b0;
    val_we     = 1'b0;
    val_waddr  = count_q[IDX_W-1:0];
    val_re     = 1'b0;
    val_raddr  = idx_q;
    stk_we     = 1'b0;
    stk_waddr  = IDX_W'(depth_q - CNT_W'(1));
    stk_re     = 1'b0;
    stk_raddr  = IDX_W'(depth_q - CNT_W'(2));
    rs_we      = 1'b0;
    ls_we      = 1'b0;
    span_re    = 1'b0;
    span_waddr = top_idx_q;
    span_wdata = pop_span;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (count_q < CNT_W'(MAX_ITEMS)) begin
            val_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            pass_d  = PASS_RIGHT;
            idx_d   = '0;
            depth_d = '0;
          end
        end
      end
      S_FETCH: begin
        val_re = 1'b1;
      end
      S_CMP: begin
        if (pop_hit) begin
          rs_we   = (pass_q == PASS_RIGHT);
          ls_we   = (pass_q == PASS_LEFT);
          depth_d = depth_q - CNT_W'(1);
          stk_re  = (depth_q >= CNT_W'(2));
        end else begin
          stk_we    = (depth_q != '0);
          top_idx_d = idx_q;
          top_val_d = val_rdata;
          depth_d   = depth_q + CNT_W'(1);
          if (!at_end) begin
            idx_d     = idx_next;
            val_re    = 1'b1;
            val_raddr = idx_next;
          end
        end
      end
      S_POPW, S_DRAINW: begin
        top_idx_d = stk_rdata[STK_W-1:VALUE_W];
        top_val_d = stk_rdata[VALUE_W-1:0];
      end
      S_DRAIN: begin
        span_wdata = drain_span;
        if (depth_q != '0) begin
          rs_we   = (pass_q == PASS_RIGHT);
          ls_we   = (pass_q == PASS_LEFT);
          depth_d = depth_q - CNT_W'(1);
          stk_re  = (depth_q >= CNT_W'(2));
        end else if (pass_q == PASS_RIGHT) begin
          pass_d = PASS_LEFT;
          idx_d  = last_idx;
        end else begin
          idx_d = '0;
        end
      end
      S_SUM: begin
        val_re   = 1'b1;
        span_re  = 1'b1;
        rd_vld_d = 1'b1;
        if (idx_q != last_idx) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_FLUSH: begin
      end
      S_OUT: begin
        count_d = '0;
        depth_d = '0;
        ovf_d   = 1'b0;
        acc_d   = '0;
      end
      default: begin
      end
    endcase

    // Summing pipeline: value*(left+1), then *(right+1), then accumulate.
    p1_vld_d = rd_vld_q;
    p1_d     = P1_W'(val_rdata) * P1_W'({1'b0, ls_rdata} + CNT_W'(1));
    r1_d     = {1'b0, rs_rdata} + CNT_W'(1);
    p2_vld_d = p1_vld_q;
    p2_d     = TOTAL_W'(p1_q) * TOTAL_W'(r1_q);
    if (p2_vld_q) begin
      acc_d = acc_q + p2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pass_q   <= PASS_RIGHT;
      count_q  <= '0;
      depth_q  <= '0;
      idx_q    <= '0;
      ovf_q    <= 1'b0;
      rd_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      state_q  <= state_d;
      pass_q   <= pass_d;
      count_q  <= count_d;
      depth_q  <= depth_d;
      idx_q    <= idx_d;
      ovf_q    <= ovf_d;
      rd_vld_q <= rd_vld_d;
      p1_vld_q <= p1_vld_d;
      p2_vld_q <= p2_vld_d;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_idx_q <= top_idx_d;
    top_val_q <= top_val_d;
    p1_q      <= p1_d;
    r1_q      <= r1_d;
    p2_q      <= p2_d;
  end

  // The result is shown in its own cycle straight from registers.
  assign busy       = (state_q != S_IDLE);
  assign done_o     = (state_q == S_OUT);
  assign total_o    = acc_q;
  assign overflow_o = ovf_q;

  // The stack never holds more indices than there are stored values.
  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= count_q)
    else $error("stack depth exceeds stored count");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("stored count exceeds capacity");

  // A closing request always starts a finishing run.
  a_last_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> busy)
    else $error("closing request did not start finishing");

  // The summing pipeline is empty whenever new requests can be taken.
  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!rd_vld_q && !p1_vld_q && !p2_vld_q))
    else $error("summing pipeline active while idle");

  // After a result the sequence state is cleared for the next one.
  a_clear_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && count_q == '0 && !ovf_q && acc_q == '0))
    else $error("sequence state not cleared after result");

endmodule
